// File: rtl/assert_macros.svh
// Assertion macros for the RTL of the queue admission block, used by fsqa_ctrl.
// Depends on nothing; the including module must provide clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge, suspended while reset is asserted.
`define FSQA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked at every rising edge, also during reset.
`define FSQA_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: rtl/fsqa_pkg.sv
// Shared types and constants of the fixed service queue admission unit.
// Depends on nothing; imported by fsqa_ctrl and the top level.
package fsqa_pkg;

  localparam int ARR_W  = 31;
  localparam int TIME_W = 32;
  localparam int SVC_W  = 16;
  localparam int MAXW_W = 4;
  localparam int CFG_IDX_W = 8;

  localparam int WAIT_DEPTH_DEF = 16;

  localparam logic [SVC_W-1:0]  SERVICE_TIME_RST = 16'd300;
  localparam logic [MAXW_W-1:0] MAX_WAITING_RST  = 4'd1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_SERVICE_TIME = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_WAITING  = 8'd1;

  typedef struct packed {
    logic [TIME_W-1:0] finish;
    logic              dropped;
  } res_t;

endpackage

// File: rtl/fsqa_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing; holds the finish times of waiting requests.
module fsqa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/fsqa_ctrl.sv
// Sequencer of the queue admission unit: retires waiting entries from the
// ring RAM one per cycle, then admits or drops the request. Uses fsqa_pkg.
module fsqa_ctrl
  import fsqa_pkg::*;
#(
  parameter int WAIT_DEPTH = WAIT_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [ARR_W-1:0]              in_arrival_time,
  input  logic [SVC_W-1:0]              service_time,
  input  logic [MAXW_W-1:0]             max_waiting,
  input  logic                          res_ready,
  output logic                          res_valid,
  output res_t                          res,
  output logic                          ram_we,
  output logic [$clog2(WAIT_DEPTH)-1:0] ram_waddr,
  output logic [TIME_W-1:0]             ram_wdata,
  output logic                          ram_re,
  output logic [$clog2(WAIT_DEPTH)-1:0] ram_raddr,
  input  logic [TIME_W-1:0]             ram_rdata
);

`include "assert_macros.svh"

  localparam int IDX_W = $clog2(WAIT_DEPTH);
  localparam int CNT_W = $clog2(WAIT_DEPTH + 1);
  localparam int SUM_W = IDX_W + 1;
  localparam int CMP_W = (CNT_W > MAXW_W) ? CNT_W : MAXW_W;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } state_t;

  state_t            state_r, state_nxt;
  logic [ARR_W-1:0]  arr_r, arr_nxt;
  logic [IDX_W-1:0]  head_r, head_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [TIME_W-1:0] last_r, last_nxt;

  logic [IDX_W-1:0]  head_inc;
  logic [SUM_W-1:0]  tail_sum;
  logic [IDX_W-1:0]  tail;
  logic [TIME_W-1:0] arr_ext;
  logic              retire;
  logic              room_full;
  logic              late;
  logic              ring_full;
  logic              drop;
  logic              enqueue;
  logic [TIME_W-1:0] base;
  logic [TIME_W:0]   sum;
  logic [TIME_W-1:0] fin;

  assign arr_ext  = {1'b0, arr_r};
  assign head_inc = (head_r == IDX_W'(WAIT_DEPTH - 1)) ? '0 : head_r + 1'b1;
  assign tail_sum = SUM_W'(head_r) + SUM_W'(count_r);
  assign tail     = (tail_sum >= SUM_W'(WAIT_DEPTH)) ?
                    IDX_W'(tail_sum - SUM_W'(WAIT_DEPTH)) : IDX_W'(tail_sum);

  // The RAM output holds the entry at head_r while scanning.
  assign retire    = (count_r != '0) && (ram_rdata <= arr_ext);
  assign room_full = CMP_W'(count_r) > CMP_W'(max_waiting);
  assign late      = arr_ext < last_r;
  assign ring_full = count_r == CNT_W'(WAIT_DEPTH);
  assign drop      = room_full || (late && ring_full);
  assign enqueue   = !drop && late;
  assign base      = late ? last_r : arr_ext;
  assign sum       = {1'b0, base} + (TIME_W + 1)'(service_time);
  assign fin       = drop ? arr_ext : (sum[TIME_W] ? '1 : sum[TIME_W-1:0]);

  assign in_ready  = (state_r == ST_IDLE);
  assign ram_waddr = tail;
  assign ram_wdata = fin;

  always_comb begin
    state_nxt   = state_r;
    arr_nxt     = arr_r;
    head_nxt    = head_r;
    count_nxt   = count_r;
    last_nxt    = last_r;
    ram_re      = 1'b0;
    ram_raddr   = head_r;
    ram_we      = 1'b0;
    res_valid   = 1'b0;
    res.finish  = fin;
    res.dropped = drop;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          arr_nxt   = in_arrival_time;
          ram_re    = 1'b1;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (retire) begin
          head_nxt  = head_inc;
          count_nxt = count_r - 1'b1;
          ram_re    = 1'b1;
          ram_raddr = head_inc;
        end else if (res_ready) begin
          res_valid = 1'b1;
          state_nxt = ST_IDLE;
          if (!drop) begin
            last_nxt = fin;
          end
          if (enqueue) begin
            ram_we    = 1'b1;
            count_nxt = count_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      head_r  <= '0;
      count_r <= '0;
      last_r  <= '0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      count_r <= count_nxt;
      last_r  <= last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    arr_r <= arr_nxt;
  end

  `FSQA_ASSERT(a_count_bound, count_r <= CNT_W'(WAIT_DEPTH), "wait count beyond ring depth")
  `FSQA_ASSERT(a_drop_finish, (res_valid && res.dropped) |-> (res.finish == arr_ext),
    "dropped request must finish at its arrival")
  `FSQA_ASSERT(a_write_admit, ram_we |-> (res_valid && !res.dropped && late),
    "ring written without admitting a late request")
  `FSQA_ASSERT(a_done_idle, res_valid |=> (state_r == ST_IDLE), "sequencer not idle after result")

endmodule

// File: rtl/fixed_service_queue_admission_unit.sv
// Top level of the fixed service queue admission unit.
// Depends on fsqa_pkg, fsqa_ctrl and fsqa_ram.
//
// Usage:
//   Arrival times enter on the in_ channel (valid/ready); each accepted beat
//   yields exactly one result beat on the out_ channel carrying the finish
//   time and a dropped flag. service_time and max_waiting are written on the
//   cfg_ channel (index 0 and 1); cfg_ready is always high, and writes to
//   other indexes are ignored. Configuration is to be written by the user
//   only while idle; the block does not enforce this. Each item retires k
//   waiting entries (0 to WAIT_DEPTH) before its decision; the ring RAM's
//   single read port sets the pace: the sequencer examines one head entry
//   per cycle through a registered read.
//   The result sits in an output register; the next arrival is accepted while
//   it waits, and the sequencer holds its decision only when that register
//   is still full. in_ready is high whenever the sequencer is idle.
//   Reset (synchronous, active low) restores the register defaults, empties
//   the waiting room and clears the last finish time; the ring RAM needs no
//   clearing pass since only entries below the wait count are read.
module fixed_service_queue_admission_unit
  import fsqa_pkg::*;
#(
  parameter int WAIT_DEPTH = WAIT_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [ARR_W-1:0]     in_arrival_time,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [TIME_W-1:0]    out_finish_time,
  output logic                 out_dropped,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SVC_W-1:0]     cfg_wdata
);

  localparam int IDX_W = $clog2(WAIT_DEPTH);

  logic [SVC_W-1:0]  svc_r, svc_nxt;
  logic [MAXW_W-1:0] maxw_r, maxw_nxt;
  logic              out_valid_r, out_valid_nxt;
  res_t              out_r, out_nxt;

  logic              res_ready;
  logic              res_valid;
  res_t              res;
  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  logic [TIME_W-1:0] ram_wdata;
  logic              ram_re;
  logic [IDX_W-1:0]  ram_raddr;
  logic [TIME_W-1:0] ram_rdata;

  assign cfg_ready = 1'b1;
  assign res_ready = !out_valid_r || out_ready;

  always_comb begin
    svc_nxt  = svc_r;
    maxw_nxt = maxw_r;
    if (cfg_valid) begin
      case (cfg_index)
        CFG_SERVICE_TIME: svc_nxt  = cfg_wdata;
        CFG_MAX_WAITING:  maxw_nxt = cfg_wdata[MAXW_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    if (res_valid) begin
      out_valid_nxt = 1'b1;
      out_nxt       = res;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      svc_r       <= SERVICE_TIME_RST;
      maxw_r      <= MAX_WAITING_RST;
      out_valid_r <= 1'b0;
    end else begin
      svc_r       <= svc_nxt;
      maxw_r      <= maxw_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_finish_time = out_r.finish;
  assign out_dropped     = out_r.dropped;

  fsqa_ctrl #(
    .WAIT_DEPTH(WAIT_DEPTH)
  ) u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_arrival_time(in_arrival_time),
    .service_time   (svc_r),
    .max_waiting    (maxw_r),
    .res_ready      (res_ready),
    .res_valid      (res_valid),
    .res            (res),
    .ram_we         (ram_we),
    .ram_waddr      (ram_waddr),
    .ram_wdata      (ram_wdata),
    .ram_re         (ram_re),
    .ram_raddr      (ram_raddr),
    .ram_rdata      (ram_rdata)
  );

  fsqa_ram #(
    .WIDTH(TIME_W),
    .DEPTH(WAIT_DEPTH)
  ) u_ring (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

endmodule
